// ===== src/ipv4fx_pkg.sv =====
// Shared types and constants for the IPv4 flow header extractor.
// No dependencies; the top level and the input, capture and output stages import it.
package ipv4fx_pkg;

    localparam int MAX_FRAME_DEF     = 16383;
    localparam int PAYLOAD_BYTES_DEF = 8;

    // Frame layout, byte offsets from the first wire byte
    localparam int ETH_HDR        = 14;
    localparam int IP_MIN_END     = 34;
    localparam int IDX_ETYPE_HI   = 12;
    localparam int IDX_ETYPE_LO   = 13;
    localparam int IDX_IHL        = 14;
    localparam int IDX_PROTO      = 23;
    localparam int IDX_SRC_FIRST  = 26;
    localparam int IDX_SRC_LAST   = 29;
    localparam int IDX_DST_FIRST  = 30;
    localparam int IDX_DST_LAST   = 33;
    localparam int TCP_OFF_POS    = 12;
    localparam int TCP_HDR_MIN    = 20;
    localparam int UDP_HDR        = 8;
    localparam int EARLY_SLOTS    = 3;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  ip_protocol;
        logic [63:0] payload_head;
    } record_t;

    typedef struct packed {
        logic    emit;
        record_t rec;
    } result_t;

endpackage

// ===== src/ipv4fx_byte_if.sv =====
// Byte stream channel into the IPv4 flow header extractor.
// Valid/ready handshake; no dependencies.
interface ipv4fx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, frame_byte, last_byte, input ready);
    modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

// ===== src/ipv4fx_flow_if.sv =====
// Flow record channel out of the IPv4 flow header extractor.
// Valid/ready handshake; no dependencies.
interface ipv4fx_flow_if;
    logic        valid;
    logic        ready;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  ip_protocol;
    logic [63:0] payload_head;

    modport source (output valid, src_addr, dst_addr, src_port, dst_port, ip_protocol,
                    payload_head, input ready);
    modport sink   (input valid, src_addr, dst_addr, src_port, dst_port, ip_protocol,
                    payload_head, output ready);
endinterface

// ===== src/ipv4_flow_header_extractor.sv =====
// IPv4 flow header extractor: top level.
// Depends on ipv4fx_pkg, both channel interfaces and the three stage modules.
//
// Takes an Ethernet frame one byte per transaction and, at the last byte, emits
// one flow record (addresses, ports, protocol, first payload bytes) or nothing
// for short, non-IPv4 or truncated frames. A byte is accepted every clock unless
// the input stalls; each byte passes the input register and one capture step. A
// record is decided as its last byte leaves the input register and is then held
// in the result register, which presents it. The input stalls only while the last
// byte of a frame waits in the input register because a finished record still
// occupies the result register and the sink is not taking it.
module ipv4_flow_header_extractor
    import ipv4fx_pkg::*;
#(
    parameter int MAX_FRAME     = MAX_FRAME_DEF,
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    ipv4fx_byte_if.sink    frame,
    ipv4fx_flow_if.source  flow
);

    logic       held;
    byte_item_t item;
    logic       out_free;
    logic       advance;
    logic       load;
    result_t    res;

    // Hold a last byte until the result register can take its record
    assign advance = held && (!item.last_byte || out_free);
    assign load    = advance && res.emit;

    ipv4fx_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame   (frame),
        .advance (advance),
        .held    (held),
        .item    (item)
    );

    ipv4fx_capture #(
        .MAX_FRAME     (MAX_FRAME),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_capture (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item),
        .res   (res)
    );

    ipv4fx_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .rec   (res.rec),
        .free  (out_free),
        .flow  (flow)
    );

    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (load && flow.valid) |-> flow.ready)
        else $error("record loaded over an untaken record");

    a_emit_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.emit |-> item.last_byte)
        else $error("record decided on a byte that does not end the frame");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> flow.valid)
        else $error("loaded record not presented");

    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        !frame.ready |-> (held && item.last_byte && !out_free))
        else $error("input stalled without a blocked last byte");

endmodule

// ===== src/ipv4fx_in_stage.sv =====
// Input register: holds one byte transaction until the capture step takes it.
// Depends on ipv4fx_pkg and ipv4fx_byte_if.
module ipv4fx_in_stage
    import ipv4fx_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    ipv4fx_byte_if.sink      frame,
    input  logic             advance,
    output logic             held,
    output byte_item_t       item
);

    logic       valid_reg;
    logic       valid_next;
    byte_item_t item_reg;
    logic       load;

    assign frame.ready = !valid_reg || advance;
    assign load        = frame.valid && frame.ready;
    assign valid_next  = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= '{frame_byte: frame.frame_byte, last_byte: frame.last_byte};
        end
    end

    assign held = valid_reg;
    assign item = item_reg;

endmodule

// ===== src/ipv4fx_capture.sv =====
// Per-frame header state: byte counter, captured fields, payload window and
// the end-of-frame record decision. Depends on ipv4fx_pkg.
module ipv4fx_capture
    import ipv4fx_pkg::*;
#(
    parameter int MAX_FRAME     = MAX_FRAME_DEF,
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  byte_item_t item,
    output result_t    res
);

    localparam int CW   = $clog2(MAX_FRAME + 1);
    localparam int CMPW = (CW > 9) ? CW : 9;
    localparam logic [63:0] PAY_MASK = {64{1'b1}} >> (64 - 8 * PAYLOAD_BYTES);

    logic [CW-1:0] byte_index_reg, byte_index_next;
    logic [15:0]   ether_kind_reg, ether_kind_next;
    logic [3:0]    header_words_reg, header_words_next;
    logic [7:0]    proto_seen_reg, proto_seen_next;
    logic [31:0]   source_seen_reg, source_seen_next;
    logic [31:0]   dest_seen_reg, dest_seen_next;
    logic [15:0]   sport_seen_reg, sport_seen_next;
    logic [15:0]   dport_seen_reg, dport_seen_next;
    logic [3:0]    tcp_offset_words_reg, tcp_offset_words_next;
    logic [63:0]   payload_seen_reg, payload_seen_next;
    logic [63:0]   recent_reg, recent_next;
    logic [63:0]   early_reg [EARLY_SLOTS];
    logic [63:0]   early_next [EARLY_SLOTS];

    logic [7:0]      b;
    logic            active;
    logic [CMPW-1:0] idx;
    logic [CMPW-1:0] t_pos;
    logic [CMPW-1:0] pay_pos;
    logic [CMPW-1:0] len;
    logic [CMPW-1:0] p_pos;
    logic            is_tcp;
    logic            is_udp;
    logic [63:0]     pay;
    record_t         rec;
    logic            emit;

    assign b      = item.frame_byte;
    assign active = byte_index_reg < CW'(MAX_FRAME);
    assign idx    = CMPW'(byte_index_reg);

    // Capture the current byte at its header position
    always_comb
    begin
        byte_index_next       = byte_index_reg;
        ether_kind_next       = ether_kind_reg;
        header_words_next     = header_words_reg;
        proto_seen_next       = proto_seen_reg;
        source_seen_next      = source_seen_reg;
        dest_seen_next        = dest_seen_reg;
        sport_seen_next       = sport_seen_reg;
        dport_seen_next       = dport_seen_reg;
        tcp_offset_words_next = tcp_offset_words_reg;
        payload_seen_next     = payload_seen_reg;
        recent_next           = recent_reg;
        for (int d = 0; d < EARLY_SLOTS; d++)
        begin
            early_next[d] = early_reg[d];
        end

        if (active)
        begin
            byte_index_next = byte_index_reg + 1'b1;
            if (idx == CMPW'(IDX_ETYPE_HI)) ether_kind_next[15:8] = b;
            if (idx == CMPW'(IDX_ETYPE_LO)) ether_kind_next[7:0] = b;
            if (idx == CMPW'(IDX_IHL))      header_words_next = b[3:0];
            if (idx == CMPW'(IDX_PROTO))    proto_seen_next = b;
            if (idx >= CMPW'(IDX_SRC_FIRST) && idx <= CMPW'(IDX_SRC_LAST))
                source_seen_next = {source_seen_reg[23:0], b};
            if (idx >= CMPW'(IDX_DST_FIRST) && idx <= CMPW'(IDX_DST_LAST))
                dest_seen_next = {dest_seen_reg[23:0], b};
        end
        t_pos = CMPW'(ETH_HDR) + CMPW'({header_words_next, 2'b00});
        if (active)
        begin
            if (idx == t_pos || idx == t_pos + CMPW'(1))
                sport_seen_next = {sport_seen_reg[7:0], b};
            if (idx == t_pos + CMPW'(2) || idx == t_pos + CMPW'(3))
                dport_seen_next = {dport_seen_reg[7:0], b};
            if (idx == t_pos + CMPW'(TCP_OFF_POS))
                tcp_offset_words_next = b[7:4];
            recent_next = {recent_reg[55:0], b};
            // Early latches cover TCP data offsets below three words; the last also serves UDP
            for (int d = 0; d < EARLY_SLOTS; d++)
            begin
                if (idx == t_pos + CMPW'(4 * d) + CMPW'(PAYLOAD_BYTES - 1))
                    early_next[d] = recent_next & PAY_MASK;
            end
        end
        pay_pos = t_pos + CMPW'({tcp_offset_words_next, 2'b00}) + CMPW'(PAYLOAD_BYTES - 1);
        if (active && tcp_offset_words_next >= 4'd3 &&
            idx >= t_pos + CMPW'(TCP_OFF_POS) && idx == pay_pos)
        begin
            payload_seen_next = recent_next & PAY_MASK;
        end
    end

    // End-of-frame decision on the updated state
    always_comb
    begin
        len    = CMPW'(byte_index_next);
        is_tcp = proto_seen_next == PROTO_TCP;
        is_udp = proto_seen_next == PROTO_UDP;
        p_pos  = is_tcp ? t_pos + CMPW'({tcp_offset_words_next, 2'b00})
                        : t_pos + CMPW'(UDP_HDR);
        emit   = item.last_byte;
        pay    = '0;
        rec    = '0;

        case (tcp_offset_words_next)
            4'd0:    pay = early_next[0];
            4'd1:    pay = early_next[1];
            4'd2:    pay = early_next[2];
            default: pay = payload_seen_next;
        endcase
        if (!is_tcp)
            pay = early_next[EARLY_SLOTS-1];
        if (len <= p_pos)
            pay = '0;

        if (len < CMPW'(IP_MIN_END) || ether_kind_next != ETHERTYPE_IPV4)
        begin
            emit = 1'b0;
        end
        else if (is_tcp || is_udp)
        begin
            if (len < t_pos + (is_tcp ? CMPW'(TCP_HDR_MIN) : CMPW'(UDP_HDR)))
                emit = 1'b0;
            else if (len > p_pos && len < p_pos + CMPW'(PAYLOAD_BYTES))
                emit = 1'b0;
            rec.src_port     = sport_seen_next;
            rec.dst_port     = dport_seen_next;
            rec.payload_head = pay;
        end
        rec.src_addr    = source_seen_next;
        rec.dst_addr    = dest_seen_next;
        rec.ip_protocol = proto_seen_next;
    end

    assign res = '{emit: emit, rec: rec};

    // Clear all frame state after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg       <= '0;
            ether_kind_reg       <= '0;
            header_words_reg     <= '0;
            proto_seen_reg       <= '0;
            source_seen_reg      <= '0;
            dest_seen_reg        <= '0;
            sport_seen_reg       <= '0;
            dport_seen_reg       <= '0;
            tcp_offset_words_reg <= '0;
            payload_seen_reg     <= '0;
            recent_reg           <= '0;
            for (int d = 0; d < EARLY_SLOTS; d++)
            begin
                early_reg[d] <= '0;
            end
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                byte_index_reg       <= '0;
                ether_kind_reg       <= '0;
                header_words_reg     <= '0;
                proto_seen_reg       <= '0;
                source_seen_reg      <= '0;
                dest_seen_reg        <= '0;
                sport_seen_reg       <= '0;
                dport_seen_reg       <= '0;
                tcp_offset_words_reg <= '0;
                payload_seen_reg     <= '0;
                recent_reg           <= '0;
                for (int d = 0; d < EARLY_SLOTS; d++)
                begin
                    early_reg[d] <= '0;
                end
            end
            else
            begin
                byte_index_reg       <= byte_index_next;
                ether_kind_reg       <= ether_kind_next;
                header_words_reg     <= header_words_next;
                proto_seen_reg       <= proto_seen_next;
                source_seen_reg      <= source_seen_next;
                dest_seen_reg        <= dest_seen_next;
                sport_seen_reg       <= sport_seen_next;
                dport_seen_reg       <= dport_seen_next;
                tcp_offset_words_reg <= tcp_offset_words_next;
                payload_seen_reg     <= payload_seen_next;
                recent_reg           <= recent_next;
                for (int d = 0; d < EARLY_SLOTS; d++)
                begin
                    early_reg[d] <= early_next[d];
                end
            end
        end
    end

endmodule

// ===== src/ipv4fx_out_stage.sv =====
// Result register: holds one flow record until the sink takes it.
// Depends on ipv4fx_pkg and ipv4fx_flow_if.
module ipv4fx_out_stage
    import ipv4fx_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  record_t         rec,
    output logic            free,
    ipv4fx_flow_if.source   flow
);

    logic    valid_reg;
    logic    valid_next;
    record_t rec_reg;

    assign free       = !valid_reg || flow.ready;
    assign valid_next = load ? 1'b1 : (flow.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= rec;
        end
    end

    assign flow.valid        = valid_reg;
    assign flow.src_addr     = rec_reg.src_addr;
    assign flow.dst_addr     = rec_reg.dst_addr;
    assign flow.src_port     = rec_reg.src_port;
    assign flow.dst_port     = rec_reg.dst_port;
    assign flow.ip_protocol  = rec_reg.ip_protocol;
    assign flow.payload_head = rec_reg.payload_head;

endmodule
